// ===== rtl/fkvp_pkg.sv =====
// Shared types, constants and helpers of the framed key/value parser.
package fkvp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned KeyLenW = 6;
  localparam int unsigned ValW    = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned AccW    = ValW + 3;

  localparam logic [ByteW-1:0] StartMarkerRst = 8'd60;
  localparam logic [ByteW-1:0] EndMarkerRst   = 8'd62;
  localparam logic [ByteW-1:0] SeparatorRst   = 8'd44;

  localparam logic [ByteW-1:0] ChrNul   = 8'h00;
  localparam logic [ByteW-1:0] ChrPlus  = 8'h2b;
  localparam logic [ByteW-1:0] ChrMinus = 8'h2d;
  localparam logic [ByteW-1:0] ChrZero  = 8'h30;
  localparam logic [ByteW-1:0] ChrNine  = 8'h39;
  localparam logic [ByteW-1:0] ChrSpace = 8'h20;
  localparam logic [ByteW-1:0] ChrTab   = 8'h09;
  localparam logic [ByteW-1:0] ChrCr    = 8'h0d;

  localparam logic [KeyLenW-1:0] KeyLenMax = 6'd63;
  localparam logic [ValW-1:0]    MagLimit  = 32'h8000_0000;
  localparam logic [ValW-1:0]    PosMax    = 32'h7fff_ffff;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_MARKER = 2'd0,
    CFG_END_MARKER   = 2'd1,
    CFG_SEPARATOR    = 2'd2
  } cfg_index_e;

  typedef enum logic [2:0] {
    PH_SKIP_KEY = 3'd0,
    PH_KEY      = 3'd1,
    PH_SKIP_VAL = 3'd2,
    PH_SPACE    = 3'd3,
    PH_SIGN     = 3'd4,
    PH_DIGITS   = 3'd5,
    PH_DONE     = 3'd6
  } parse_phase_e;

  typedef struct packed {
    logic [ByteW-1:0] start_marker;
    logic [ByteW-1:0] end_marker;
    logic [ByteW-1:0] separator;
  } fkvp_cfg_t;

  typedef struct packed {
    logic [KeyW-1:0]    key_text;
    logic [KeyLenW-1:0] key_length;
    logic               key_ok;
    logic [ValW-1:0]    value;
    logic               value_present;
    logic               frame_overflow;
  } fkvp_result_t;

  function automatic logic is_space(input logic [ByteW-1:0] c);
    return (c == ChrSpace) || ((c >= ChrTab) && (c <= ChrCr));
  endfunction

endpackage

// ===== rtl/fkvp_core.sv =====
// Frame tracking and on-the-fly key/value parse of one byte per cycle while go_i is set.
module fkvp_core
  import fkvp_pkg::*;
#(
  parameter int unsigned KEY_MAX_CHARS = 4,
  parameter int unsigned BUFFER_CHARS  = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fkvp_cfg_t        cfg_i,
  input  logic [ByteW-1:0] byte_i,
  input  logic             go_i,
  output logic             emit_o,
  output fkvp_result_t     result_o
);

  localparam int unsigned CntW = $clog2(BUFFER_CHARS);
  localparam logic [CntW-1:0] CntLast = CntW'(BUFFER_CHARS - 1);
  localparam logic [KeyLenW-1:0] KeyLimit = KeyLenW'(KEY_MAX_CHARS);

  logic                open_q, open_d;
  parse_phase_e        phase_q, phase_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [KeyW-1:0]     key_q, key_d;
  logic [KeyLenW-1:0]  key_cnt_q, key_cnt_d;
  logic [ValW-1:0]     acc_q, acc_d;
  logic                neg_q, neg_d;
  logic                seen_q, seen_d;
  logic                ovf_q, ovf_d;

  logic                is_sep, is_digit;
  parse_phase_e        ph_eff;
  logic [AccW-1:0]     acc_next;
  logic                has_key, ok, present;

  assign is_sep   = (byte_i == cfg_i.separator);
  assign is_digit = (byte_i >= ChrZero) && (byte_i <= ChrNine);
  assign emit_o   = open_q && (byte_i == cfg_i.end_marker);

  // Ten times the magnitude plus the new digit, as two shifted adds.
  assign acc_next = ({3'b000, acc_q} << 3) + ({3'b000, acc_q} << 1)
                  + AccW'(byte_i - ChrZero);

  always_comb begin
    open_d    = open_q;
    phase_d   = phase_q;
    count_d   = count_q;
    key_d     = key_q;
    key_cnt_d = key_cnt_q;
    acc_d     = acc_q;
    neg_d     = neg_q;
    seen_d    = seen_q;
    ovf_d     = ovf_q;
    ph_eff    = phase_q;

    if (go_i) begin
      if (!open_q || emit_o) begin
        // Opening or closing a frame both start from a clean parse state.
        if (emit_o) begin
          open_d = 1'b0;
        end else begin
          open_d = (byte_i == cfg_i.start_marker);
        end
        if (emit_o || (byte_i == cfg_i.start_marker)) begin
          phase_d   = PH_SKIP_KEY;
          count_d   = '0;
          key_d     = '0;
          key_cnt_d = '0;
          acc_d     = '0;
          neg_d     = 1'b0;
          seen_d    = 1'b0;
          ovf_d     = 1'b0;
        end
      end else if (count_q >= CntLast) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + 1'b1;
        if (byte_i == ChrNul) begin
          phase_d = PH_DONE;
        end else begin
          // The skip phases fall into the next phase on a non-separator.
          if ((phase_q == PH_SKIP_KEY) && !is_sep) begin
            ph_eff = PH_KEY;
          end else if ((phase_q == PH_SKIP_VAL) && !is_sep) begin
            ph_eff = PH_SPACE;
            seen_d = 1'b1;
          end
          phase_d = ph_eff;
          unique case (ph_eff)
            PH_KEY: begin
              if (is_sep) begin
                phase_d = PH_SKIP_VAL;
              end else begin
                if (key_cnt_q < KeyLenW'(4)) begin
                  key_d[8*key_cnt_q[1:0] +: 8] = byte_i;
                end
                if (key_cnt_q != KeyLenMax) begin
                  key_cnt_d = key_cnt_q + 1'b1;
                end
              end
            end
            PH_SPACE, PH_SIGN, PH_DIGITS: begin
              if ((ph_eff == PH_SPACE) && is_sep) begin
                phase_d = PH_DONE;
              end else if ((ph_eff == PH_SPACE) && is_space(byte_i)) begin
                phase_d = PH_SPACE;
              end else if ((ph_eff == PH_SPACE) &&
                           ((byte_i == ChrPlus) || (byte_i == ChrMinus))) begin
                neg_d   = (byte_i == ChrMinus);
                phase_d = PH_SIGN;
              end else if (is_digit) begin
                acc_d   = (acc_next > AccW'(MagLimit)) ? MagLimit : acc_next[ValW-1:0];
                phase_d = PH_DIGITS;
              end else begin
                phase_d = PH_DONE;
              end
            end
            default: begin
              phase_d = ph_eff;
            end
          endcase
        end
      end
    end
  end

  always_comb begin
    has_key = (key_cnt_q != '0);
    ok      = has_key && (key_cnt_q <= KeyLimit);
    present = has_key && seen_q;
    result_o.key_text       = ok ? key_q : '0;
    result_o.key_length     = key_cnt_q;
    result_o.key_ok         = ok;
    result_o.value_present  = present;
    result_o.frame_overflow = ovf_q;
    if (!present) begin
      result_o.value = '0;
    end else if (neg_q) begin
      result_o.value = '0 - acc_q;
    end else begin
      result_o.value = (acc_q > PosMax) ? PosMax : acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q    <= 1'b0;
      phase_q   <= PH_SKIP_KEY;
      count_q   <= '0;
      key_q     <= '0;
      key_cnt_q <= '0;
      acc_q     <= '0;
      neg_q     <= 1'b0;
      seen_q    <= 1'b0;
      ovf_q     <= 1'b0;
    end else begin
      open_q    <= open_d;
      phase_q   <= phase_d;
      count_q   <= count_d;
      key_q     <= key_d;
      key_cnt_q <= key_cnt_d;
      acc_q     <= acc_d;
      neg_q     <= neg_d;
      seen_q    <= seen_d;
      ovf_q     <= ovf_d;
    end
  end

endmodule

// ===== rtl/fkvp_result_reg.sv =====
// Output register that holds one result word until the receiver takes it.
module fkvp_result_reg
  import fkvp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  fkvp_result_t result_i,
  input  logic         out_stall_i,
  output logic         out_valid_o,
  output logic         free_o,
  output fkvp_result_t result_o
);

  logic         vld_q, vld_d;
  fkvp_result_t res_q;

  assign free_o = !vld_q || !out_stall_i;

  always_comb begin
    if (load_i) begin
      vld_d = 1'b1;
    end else if (out_stall_i) begin
      vld_d = vld_q;
    end else begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = vld_q;
  assign result_o    = res_q;

endmodule

// ===== rtl/framed_key_value_parser.sv =====
// Top level of the framed key/value parser: ports, configuration and input register.
//
// Each received byte is captured in an input register and parsed from there by a
// single pass of logic that updates the frame state; an end marker loads the
// result register, so a result word is presented in the cycle after its end marker
// is taken. One byte is accepted every cycle while the input does not stall. The
// input stalls only while an end marker waits for the result register, which holds
// an earlier word that the receiver is stalling. Marker and separator registers take
// effect at once and are to be written only while no frame is being delivered.
module framed_key_value_parser
  import fkvp_pkg::*;
#(
  parameter int unsigned KEY_MAX_CHARS = 4,
  parameter int unsigned BUFFER_CHARS  = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [ByteW-1:0]      cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [ByteW-1:0]      rx_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [KeyW-1:0]       key_text_o,
  output logic [KeyLenW-1:0]    key_length_o,
  output logic                  key_ok_o,
  output logic signed [ValW-1:0] value_o,
  output logic                  value_present_o,
  output logic                  frame_overflow_o
);

  fkvp_cfg_t        cfg_q;
  logic             in_vld_q, in_vld_d;
  logic [ByteW-1:0] in_byte_q;
  logic             accept, go, emit, out_free, load;
  fkvp_result_t     core_res, out_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker <= StartMarkerRst;
      cfg_q.end_marker   <= EndMarkerRst;
      cfg_q.separator    <= SeparatorRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_START_MARKER: cfg_q.start_marker <= cfg_data_i;
        CFG_END_MARKER:   cfg_q.end_marker   <= cfg_data_i;
        CFG_SEPARATOR:    cfg_q.separator    <= cfg_data_i;
        default:          cfg_q              <= cfg_q;
      endcase
    end
  end

  assign go         = in_vld_q && (!emit || out_free);
  assign load       = go && emit;
  assign in_stall_o = in_vld_q && !go;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (go) begin
      in_vld_d = 1'b0;
    end else begin
      in_vld_d = in_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= rx_byte_i;
    end
  end

  fkvp_core #(
    .KEY_MAX_CHARS (KEY_MAX_CHARS),
    .BUFFER_CHARS  (BUFFER_CHARS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .byte_i   (in_byte_q),
    .go_i     (go),
    .emit_o   (emit),
    .result_o (core_res)
  );

  fkvp_result_reg u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .result_i    (core_res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .free_o      (out_free),
    .result_o    (out_res)
  );

  assign key_text_o       = out_res.key_text;
  assign key_length_o     = out_res.key_length;
  assign key_ok_o         = out_res.key_ok;
  assign value_o          = out_res.value;
  assign value_present_o  = out_res.value_present;
  assign frame_overflow_o = out_res.frame_overflow;

`ifndef SYNTHESIS
  // A new word must never overwrite one the receiver is still stalling.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(load && out_valid_o && out_stall_i))
    else $error("result register overwritten while stalled");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_o)
    else $error("loaded result not presented");

  a_key_ok_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && key_ok_o) |->
      (key_length_o != '0) && (key_length_o <= KeyLenW'(KEY_MAX_CHARS)))
    else $error("key_ok with bad key length");

  a_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !value_present_o) |-> (value_o == '0))
    else $error("value nonzero without value token");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_vld_q && emit && !out_free))
    else $error("input stalled without a waiting end marker");
`endif

endmodule
